[design/assert_macros.svh]
// Assertion helpers; the asserting module must have clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

[design/lpr_pkg.sv]
package lpr_pkg;

   localparam int MAX_ORDER    = 32;
   localparam int COEF_BITS    = 15;
   localparam int SAMPLE_BITS  = 33;
   localparam int VALUE_BITS   = 36;
   localparam int COEF_INDEX_W = 5;
   localparam int ORDER_W      = 6;
   localparam int QSHIFT_W     = 4;
   localparam int WASTED_W     = 5;
   localparam int COUNT_W      = 6;
   localparam int CSR_IDX_W    = 8;
   localparam int CSR_DATA_W   = 6;
   localparam int IDX_W        = $clog2(MAX_ORDER);
   localparam int PROD_W       = COEF_BITS + SAMPLE_BITS;
   localparam int ACC_W        = PROD_W + $clog2(MAX_ORDER);

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [CSR_IDX_W-1:0] REG_KIND   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_ORDER  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_QSHIFT = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_WASTED = CSR_IDX_W'(3);

   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_SAMPLE  = 1'b1;
   localparam logic KIND_FIXED = 1'b0;
   localparam logic KIND_LPC   = 1'b1;

   typedef logic signed [COEF_BITS-1:0]   coef_type;
   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [PROD_W-1:0]      prod_type;
   typedef logic signed [ACC_W-1:0]       acc_type;

   typedef struct packed {
      logic rotate;  // ring moves one place toward cell 0
      logic shift;   // history moves one place away from cell 0
   } cell_ctl_type;

endpackage

[design/lpr_ifs.sv]
interface lpr_req_if;
   logic                                   valid;
   logic                                   ready;
   logic                                   operation;
   logic                                   first;
   logic                                   last;
   logic [lpr_pkg::COEF_INDEX_W-1:0]       coef_index;
   logic signed [lpr_pkg::VALUE_BITS-1:0]  value;

   modport source (output valid, operation, first, last, coef_index, value, input ready);
   modport sink   (input valid, operation, first, last, coef_index, value, output ready);
endinterface

interface lpr_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [lpr_pkg::SAMPLE_BITS-1:0] sample;
   logic                                   end_of_subframe;

   modport source (output valid, sample, end_of_subframe, input ready);
   modport sink   (input valid, sample, end_of_subframe, output ready);
endinterface

interface lpr_csr_if;
   logic                               valid;
   logic                               ready;
   logic [lpr_pkg::CSR_IDX_W-1:0]      index;
   logic [lpr_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[design/lpc_predictor_restore.sv]
// Rebuilds audio samples from prediction residuals. A coefficient load
// (operation 0) writes one slot and produces no response. A sample request
// yields one response. Warm-up samples and fixed-polynomial predictions go
// from IDLE straight to FINISH, which loads the output register; an LPC
// prediction passes through MAC, DRAIN and FINISH, because the coefficient
// and history ring rotates past a single multiply-accumulate unit one tap
// per cycle, then drains the product register and finishes.
// The response sits in an output register, so the next request is taken
// while it waits; a new result stalls only if that register is still full.
// Configuration writes are always ready and must be issued while idle.
`include "assert_macros.svh"

module lpc_predictor_restore (
   input logic        clock,
   input logic        reset,
   lpr_req_if.sink    req_bus,
   lpr_rsp_if.source  rsp_bus,
   lpr_csr_if.sink    csr_bus
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_MAC    = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   // configuration
   logic                                kind_ff, kind_in;
   logic [lpr_pkg::ORDER_W-1:0]         order_ff, order_in;
   logic [lpr_pkg::QSHIFT_W-1:0]        qshift_ff, qshift_in;
   logic [lpr_pkg::WASTED_W-1:0]        wasted_ff, wasted_in;

   // sequencer
   logic [1:0]                          state_ff, state_in;
   logic [lpr_pkg::IDX_W-1:0]           tap_ff, tap_in;
   logic [lpr_pkg::COUNT_W-1:0]         count_ff, count_in;
   logic                                warm_ff, warm_in;
   logic                                last_ff, last_in;
   lpr_pkg::sample_type                 resid_ff, resid_in;

   // output register
   logic                                out_valid_ff, out_valid_in;
   lpr_pkg::sample_type                 out_sample_ff, out_sample_in;
   logic                                out_eos_ff, out_eos_in;

   logic                                req_acc, sample_acc, finish_go;
   logic [lpr_pkg::ORDER_W-1:0]         order_eff;
   logic [lpr_pkg::COUNT_W-1:0]         count_base, count_next;
   logic                                warm_now;
   lpr_pkg::cell_ctl_type               ctl;
   logic [lpr_pkg::MAX_ORDER-1:0]       coef_we;
   lpr_pkg::coef_type                   coef_q [lpr_pkg::MAX_ORDER];
   lpr_pkg::sample_type                 hist_q [lpr_pkg::MAX_ORDER];
   lpr_pkg::acc_type                    acc;
   lpr_pkg::sample_type                 lpc_pred, fixed_pred, pred, rebuilt;
   logic                                mac_take;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_acc       = req_bus.valid && req_bus.ready;
   assign sample_acc    = req_acc && (req_bus.operation == lpr_pkg::OP_SAMPLE);
   assign finish_go     = (state_ff == ST_FINISH) && (!out_valid_ff || rsp_bus.ready);

   assign order_eff = (order_ff > lpr_pkg::ORDER_W'(lpr_pkg::MAX_ORDER))
                      ? lpr_pkg::ORDER_W'(lpr_pkg::MAX_ORDER) : order_ff;

   always_comb begin
      count_base = req_bus.first ? '0 : count_ff;
      warm_now   = lpr_pkg::ORDER_W'(count_base) < order_eff;
      count_next = (count_base == lpr_pkg::COUNT_MAX) ? count_base : count_base + 1'b1;
      if (req_bus.last) begin
         count_next = '0;
      end
   end

   // configuration writes
   always_comb begin
      kind_in   = kind_ff;
      order_in  = order_ff;
      qshift_in = qshift_ff;
      wasted_in = wasted_ff;
      if (csr_bus.valid && csr_bus.ready) begin
         unique case (csr_bus.index)
            lpr_pkg::REG_KIND:   kind_in   = csr_bus.data[0];
            lpr_pkg::REG_ORDER:  order_in  = csr_bus.data[lpr_pkg::ORDER_W-1:0];
            lpr_pkg::REG_QSHIFT: qshift_in = csr_bus.data[lpr_pkg::QSHIFT_W-1:0];
            lpr_pkg::REG_WASTED: wasted_in = csr_bus.data[lpr_pkg::WASTED_W-1:0];
            default: ;
         endcase
      end
   end

   // cell ring
   assign ctl.rotate = (state_ff == ST_MAC);
   assign ctl.shift  = finish_go;

   genvar j;
   generate
      for (j = 0; j < lpr_pkg::MAX_ORDER; j++) begin : g_cell
         lpr_pkg::sample_type hist_down;
         if (j == 0) begin : g_head
            assign hist_down = rebuilt;
         end else begin : g_body
            assign hist_down = hist_q[j-1];
         end
         assign coef_we[j] = req_acc && (req_bus.operation == lpr_pkg::OP_LOAD) &&
                             (req_bus.coef_index == lpr_pkg::COEF_INDEX_W'(j));
         lpr_cell u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .coef_we    (coef_we[j]),
            .coef_wdata (req_bus.value[lpr_pkg::COEF_BITS-1:0]),
            .coef_up    (coef_q[(j + 1) % lpr_pkg::MAX_ORDER]),
            .hist_up    (hist_q[(j + 1) % lpr_pkg::MAX_ORDER]),
            .hist_down  (hist_down),
            .coef_q     (coef_q[j]),
            .hist_q     (hist_q[j])
         );
      end
   endgenerate

   // cell 0 holds tap number tap_ff while the ring rotates
   assign mac_take = (state_ff == ST_MAC) && (lpr_pkg::ORDER_W'(tap_ff) < order_eff);

   lpr_mac u_mac (
      .clock (clock),
      .reset (reset),
      .clear (sample_acc),
      .take  (mac_take),
      .coef  (coef_q[0]),
      .hist  (hist_q[0]),
      .acc   (acc)
   );

   // only the low sample bits survive the final wrap
   always_comb begin
      lpc_pred = lpr_pkg::SAMPLE_BITS'(acc >>> qshift_ff);
      unique case (order_eff)
         lpr_pkg::ORDER_W'(0): fixed_pred = '0;
         lpr_pkg::ORDER_W'(1): fixed_pred = hist_q[0];
         lpr_pkg::ORDER_W'(2): fixed_pred = (hist_q[0] <<< 1) - hist_q[1];
         lpr_pkg::ORDER_W'(3): fixed_pred = (hist_q[0] <<< 1) + hist_q[0]
                                            - (hist_q[1] <<< 1) - hist_q[1] + hist_q[2];
         default:              fixed_pred = (hist_q[0] <<< 2) - (hist_q[1] <<< 2)
                                            - (hist_q[1] <<< 1) + (hist_q[2] <<< 2)
                                            - hist_q[3];
      endcase
      pred          = (kind_ff == lpr_pkg::KIND_LPC) ? lpc_pred : fixed_pred;
      rebuilt       = warm_ff ? resid_ff : resid_ff + pred;
      out_sample_in = rebuilt <<< wasted_ff;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      tap_in       = tap_ff;
      count_in     = count_ff;
      warm_in      = warm_ff;
      last_in      = last_ff;
      resid_in     = resid_ff;
      out_eos_in   = out_eos_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (sample_acc) begin
               warm_in  = warm_now;
               last_in  = req_bus.last;
               resid_in = req_bus.value[lpr_pkg::SAMPLE_BITS-1:0];
               count_in = count_next;
               tap_in   = '0;
               state_in = (warm_now || kind_ff == lpr_pkg::KIND_FIXED) ? ST_FINISH : ST_MAC;
            end
         end
         ST_MAC: begin
            tap_in = tap_ff + 1'b1;
            if (tap_ff == lpr_pkg::IDX_W'(lpr_pkg::MAX_ORDER - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (finish_go) begin
               out_valid_in = 1'b1;
               out_eos_in   = last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff      <= lpr_pkg::KIND_FIXED;
         order_ff     <= '0;
         qshift_ff    <= '0;
         wasted_ff    <= '0;
         state_ff     <= ST_IDLE;
         tap_ff       <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         kind_ff      <= kind_in;
         order_ff     <= order_in;
         qshift_ff    <= qshift_in;
         wasted_ff    <= wasted_in;
         state_ff     <= state_in;
         tap_ff       <= tap_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      warm_ff    <= warm_in;
      last_ff    <= last_in;
      resid_ff   <= resid_in;
      out_eos_ff <= out_eos_in;
      if (finish_go) begin
         out_sample_ff <= out_sample_in;
      end
   end

   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.sample          = out_sample_ff;
   assign rsp_bus.end_of_subframe = out_eos_ff;

   `ASSERT_NEXT(a_ring_full_turn, state_ff == ST_MAC && tap_ff == lpr_pkg::IDX_W'(lpr_pkg::MAX_ORDER - 1), state_ff == ST_DRAIN, "ring did not stop after a full turn")
   `ASSERT_IMPL(a_rsp_from_finish, $rose(out_valid_ff), $past(state_ff) == ST_FINISH, "response raised outside finish")
   `ASSERT_NEXT(a_last_clears_count, sample_acc && req_bus.last, count_ff == '0, "sample count not cleared by last")

endmodule

[design/lpr_cell.sv]
module lpr_cell (
   input  logic                  clock,
   input  lpr_pkg::cell_ctl_type ctl,
   input  logic                  coef_we,
   input  lpr_pkg::coef_type     coef_wdata,
   input  lpr_pkg::coef_type     coef_up,
   input  lpr_pkg::sample_type   hist_up,
   input  lpr_pkg::sample_type   hist_down,
   output lpr_pkg::coef_type     coef_q,
   output lpr_pkg::sample_type   hist_q
);

   lpr_pkg::coef_type   coef_ff, coef_in;
   lpr_pkg::sample_type hist_ff, hist_in;

   always_comb begin
      coef_in = coef_ff;
      hist_in = hist_ff;
      if (ctl.rotate) begin
         coef_in = coef_up;
         hist_in = hist_up;
      end else if (ctl.shift) begin
         hist_in = hist_down;
      end
      if (coef_we) begin
         coef_in = coef_wdata;
      end
   end

   always_ff @(posedge clock) begin
      coef_ff <= coef_in;
      hist_ff <= hist_in;
   end

   assign coef_q = coef_ff;
   assign hist_q = hist_ff;

endmodule

[design/lpr_mac.sv]
module lpr_mac (
   input  logic                clock,
   input  logic                reset,
   input  logic                clear,
   input  logic                take,
   input  lpr_pkg::coef_type   coef,
   input  lpr_pkg::sample_type hist,
   output lpr_pkg::acc_type    acc
);

   lpr_pkg::prod_type prod_ff, prod_in;
   lpr_pkg::acc_type  acc_ff, acc_in;
   logic              take_ff, take_in;

   always_comb begin
      prod_in = lpr_pkg::PROD_W'(coef) * lpr_pkg::PROD_W'(hist);
      take_in = take && !clear;
      acc_in  = acc_ff;
      if (clear) begin
         acc_in = '0;
      end else if (take_ff) begin
         acc_in = acc_ff + lpr_pkg::ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         take_ff <= 1'b0;
      end else begin
         take_ff <= take_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule
